/* rtl/ccts_pkg.sv */
// ----------------------------------------------------------------------------
// ccts_pkg
// Shared types and constants of the crank/cam tooth sync decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ccts_pkg;

    // Edge kinds
    localparam logic OP_CRANK = 1'b0;
    localparam logic OP_CAM   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CRANK_LOCK  = 1'b0;
    localparam logic CFG_BASE_FILTER = 1'b1;

    // Reset values and fixed constants
    localparam logic [7:0]  NO_SYNC_COUNT   = 8'd99;
    localparam logic [15:0] RESET_FILTER    = 16'd1500;
    localparam logic [6:0]  ANGLE_SHORT     = 7'd72;
    localparam logic [6:0]  ANGLE_LONG      = 7'd108;
    localparam logic [7:0]  TOOTH_ONE       = 8'd1;
    localparam logic [7:0]  TOOTH_THREE     = 8'd3;
    localparam logic [7:0]  TOOTH_WRAP      = 8'd5;
    localparam logic [7:0]  CAM_ARMED       = 8'd2;

    // One edge transaction
    typedef struct packed {
        logic        operation;
        logic [31:0] timestamp;
        logic        cranking;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic        valid_trigger;
        logic        sync_flag;
        logic [7:0]  tooth_number;
        logic        end_coil_one;
        logic        end_coil_two;
        logic [6:0]  gap_angle;
        logic [31:0] filter_out;
        logic [31:0] last_tooth_out;
        logic [31:0] prior_tooth_out;
        logic [15:0] revolutions_out;
        logic [7:0]  cam_count_out;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/ccts_fifo.sv */
// ----------------------------------------------------------------------------
// ccts_fifo
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/ccts_core.sv */
// ----------------------------------------------------------------------------
// ccts_core
// Back end: applies one edge per cycle to the decoder state unless the result
// queue is full, and builds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire ccts_pkg::t_in_item i_item,
    input  wire logic               i_item_valid,
    output logic                    o_item_take,
    output ccts_pkg::t_out_item     o_result,
    output logic                    o_result_push,
    input  wire logic               i_result_full
);
    import ccts_pkg::*;

    // Configuration
    logic        r_crank_lock;
    logic [15:0] r_base_filter;

    // Decoder state
    logic [31:0] r_last_crank, n_last_crank;
    logic [31:0] r_prior_crank, n_prior_crank;
    logic [7:0]  r_tooth, n_tooth;
    logic [31:0] r_filter, n_filter;
    logic [6:0]  r_angle, n_angle;
    logic        r_sync, n_sync;
    logic [15:0] r_revs, n_revs;
    logic [31:0] r_last_cam, n_last_cam;
    logic [31:0] r_cam_gap, n_cam_gap;
    logic [7:0]  r_cam, n_cam;

    logic        fire;
    logic [31:0] crank_gap, cam_gap;
    logic [33:0] gap_x3;
    logic [7:0]  tooth_inc, tooth_new, cam_base;
    logic        tooth_wrap, sync_new;
    logic        valid_trig, coil_one, coil_two;

    assign fire          = i_item_valid && !i_result_full;
    assign o_item_take   = fire;
    assign o_result_push = fire;

    assign crank_gap  = i_item.timestamp - r_last_crank;
    assign cam_gap    = i_item.timestamp - r_last_cam;
    assign gap_x3     = {2'b00, crank_gap} + {1'b0, crank_gap, 1'b0};
    assign tooth_inc  = r_tooth + 8'd1;
    assign tooth_wrap = (tooth_inc == TOOTH_ONE) || (tooth_inc == TOOTH_WRAP);
    assign tooth_new  = tooth_wrap ? TOOTH_ONE : tooth_inc;
    assign sync_new   = r_sync || tooth_wrap;

    // Next-state of the decoder for the edge at the queue head
    always_comb begin
        n_last_crank  = r_last_crank;
        n_prior_crank = r_prior_crank;
        n_tooth       = r_tooth;
        n_filter      = r_filter;
        n_angle       = r_angle;
        n_sync        = r_sync;
        n_revs        = r_revs;
        n_last_cam    = r_last_cam;
        n_cam_gap     = r_cam_gap;
        n_cam         = r_cam;
        valid_trig    = 1'b0;
        coil_one      = 1'b0;
        coil_two      = 1'b0;
        cam_base      = r_cam;
        if (i_item.operation == OP_CRANK) begin
            if (crank_gap >= r_filter) begin
                valid_trig = 1'b1;
                n_tooth    = tooth_new;
                if (tooth_wrap) begin
                    n_sync = 1'b1;
                    n_revs = r_revs + 16'd1;
                end
                if (sync_new) begin
                    // coil-end pulses while cranking under crank lock
                    if (i_item.cranking && r_crank_lock) begin
                        coil_one = (tooth_new == TOOTH_ONE);
                        coil_two = (tooth_new == TOOTH_THREE);
                    end
                    if (tooth_new == TOOTH_ONE || tooth_new == TOOTH_THREE) begin
                        n_angle  = ANGLE_SHORT;
                        n_filter = crank_gap;
                    end else begin
                        n_angle  = ANGLE_LONG;
                        n_filter = {1'b0, gap_x3[33:3]};
                    end
                    n_prior_crank = r_last_crank;
                    n_last_crank  = i_item.timestamp;
                end
            end
        end else begin
            n_cam_gap  = cam_gap;
            n_last_cam = i_item.timestamp;
            if (!r_sync) begin
                if (r_cam == CAM_ARMED) begin
                    n_tooth = TOOTH_ONE;
                    n_sync  = 1'b1;
                end else begin
                    n_filter = {16'd0, r_base_filter};
                    // short cam gap loads the cam count from the armed value
                    if (cam_gap < {1'b0, r_cam_gap[31:1]}) begin
                        cam_base = CAM_ARMED;
                    end
                end
                n_cam = cam_base + 8'd1;
            end
        end
    end

    // Result built from the updated state
    always_comb begin
        o_result.valid_trigger   = valid_trig;
        o_result.sync_flag       = n_sync;
        o_result.tooth_number    = n_tooth;
        o_result.end_coil_one    = coil_one;
        o_result.end_coil_two    = coil_two;
        o_result.gap_angle       = n_angle;
        o_result.filter_out      = n_filter;
        o_result.last_tooth_out  = n_last_crank;
        o_result.prior_tooth_out = n_prior_crank;
        o_result.revolutions_out = n_revs;
        o_result.cam_count_out   = n_cam;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crank_lock  <= 1'b0;
            r_base_filter <= RESET_FILTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CRANK_LOCK:  r_crank_lock  <= i_cfg_wdata[0];
                CFG_BASE_FILTER: r_base_filter <= i_cfg_wdata;
                default:         r_crank_lock  <= r_crank_lock;
            endcase
        end
    end

    // Decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_crank  <= '0;
            r_prior_crank <= '0;
            r_tooth       <= NO_SYNC_COUNT;
            r_filter      <= {16'd0, RESET_FILTER};
            r_angle       <= ANGLE_LONG;
            r_sync        <= 1'b0;
            r_revs        <= '0;
            r_last_cam    <= '0;
            r_cam_gap     <= '0;
            r_cam         <= '0;
        end else if (fire) begin
            r_last_crank  <= n_last_crank;
            r_prior_crank <= n_prior_crank;
            r_tooth       <= n_tooth;
            r_filter      <= n_filter;
            r_angle       <= n_angle;
            r_sync        <= n_sync;
            r_revs        <= n_revs;
            r_last_cam    <= n_last_cam;
            r_cam_gap     <= n_cam_gap;
            r_cam         <= n_cam;
        end
    end

endmodule

`default_nettype wire

/* rtl/crank_cam_tooth_sync_decoder.sv */
// ----------------------------------------------------------------------------
// crank_cam_tooth_sync_decoder
// Crank/cam trigger wheel decoder: edge queue, decoder core, result queue.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake         | Payload
//  ----------+-----------+-------------------+-------------------------
//  edges     | in        | push / full       | i_in_item  (t_in_item)
//  results   | out       | empty / pop       | o_result   (t_out_item)
//  config    | in        | i_cfg_we          | i_cfg_index, i_cfg_wdata
//
//  One edge per clock is decoded by the core while the result queue is not
//  full, so one result leaves per cycle in steady state.
//  An accepted edge is registered in the edge queue, decoded by the core
//  from the queue head, and its result registered in the result queue, from
//  whose head it can then be popped.
//  Reset clears pointers and core state, not queue storage; no clearing pass.
//  A full result queue stalls the core; the edge queue keeps taking edges
//  until it is full too.
// ----------------------------------------------------------------------------
`default_nettype none

module crank_cam_tooth_sync_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ccts_pkg::t_in_item  i_in_item,
    output logic                     empty,
    input  wire logic                pop,
    output ccts_pkg::t_out_item      o_result,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_wdata
);
    import ccts_pkg::*;

    localparam int IN_W  = $bits(t_in_item);
    localparam int OUT_W = $bits(t_out_item);

    t_in_item  head_item;
    t_out_item core_result;
    logic      edge_empty, edge_take, result_push, result_full;

    // Front: edge transaction queue
    ccts_fifo #(
        .WIDTH (IN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_edge_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_in_item),
        .o_full  (full),
        .i_pop   (edge_take),
        .o_data  (head_item),
        .o_empty (edge_empty)
    );

    // Back: decoder core
    ccts_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (head_item),
        .i_item_valid  (!edge_empty),
        .o_item_take   (edge_take),
        .o_result      (core_result),
        .o_result_push (result_push),
        .i_result_full (result_full)
    );

    // Result transaction queue
    ccts_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .i_data  (core_result),
        .o_full  (result_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

/* rtl/ccts_checker.sv */
// ----------------------------------------------------------------------------
// ccts_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                empty,
    input  wire logic                pop,
    input  wire ccts_pkg::t_out_item o_result
);
    import ccts_pkg::*;

    // A waiting result does not vanish
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result vanished without pop");

    // A waiting result does not change
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_result))
        else $error("waiting result changed");

    // With sync the tooth count stays within one to four
    a_tooth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.sync_flag |->
            (o_result.tooth_number >= TOOTH_ONE && o_result.tooth_number < TOOTH_WRAP))
        else $error("tooth count out of range under sync");

    // Coil-end pulses only on a passed, synced crank edge, never both
    a_coil_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.end_coil_one || o_result.end_coil_two) |->
            (o_result.valid_trigger && o_result.sync_flag &&
             !(o_result.end_coil_one && o_result.end_coil_two)))
        else $error("coil pulse without synced trigger");

    // Gap angle is always one of the two wheel gaps
    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.gap_angle == ANGLE_SHORT ||
                    o_result.gap_angle == ANGLE_LONG))
        else $error("bad gap angle");

endmodule

bind crank_cam_tooth_sync_decoder ccts_checker u_ccts_checker (.*);

`default_nettype wire
